FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define DRBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drbt check failed");

// next-cycle implication, checked at every rising edge outside reset
`define DRBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drbt check failed");

`endif

FILE: src/drbt_pkg.sv
// shared types and constants of the device retry backoff table
package drbt_pkg;

	localparam int ADDR_W    = 48;
	localparam int TIME_W    = 48;
	localparam int CNT_W     = 8;
	localparam int BASE_W    = 20;
	localparam int MAX_W     = 22;
	localparam int RETRY_W   = 20;
	localparam int TRIES_W   = 8;
	localparam int CFG_W     = 22;
	localparam int CFG_IDX_W = 2;
	localparam int SHIFT_W   = 3;
	localparam int SHL_W     = BASE_W + 5;

	localparam logic [CNT_W-1:0] COUNT_CAP = 8'd255;
	localparam logic [CNT_W-1:0] SHIFT_CAP = 8'd5;

	// action codes
	localparam logic [1:0] ACT_ADVERTISE   = 2'd0;
	localparam logic [1:0] ACT_SESSION_END = 2'd1;
	localparam logic [1:0] ACT_CLEAR       = 2'd2;
	localparam logic [1:0] ACT_QUERY       = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_RETRY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIRING_TRIES = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] device_address;
		logic [TIME_W-1:0] time_ms;
		logic              match_found;
		logic [3:0]        match_family;
		logic [7:0]        match_variant;
		logic              wants_backoff;
		logic              was_published;
		logic              pair_failed;
		logic              conn_failed;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic       is_active;
		logic [3:0] granted_family;
		logic [7:0] granted_variant;
	} rsp_t;

	// what the cell row does with the token that passes through it
	typedef enum logic [2:0] {
		MODE_NONE  = 3'd0,
		MODE_LOOK  = 3'd1,
		MODE_WRHIT = 3'd2,
		MODE_TAKE  = 3'd3,
		MODE_CLEAR = 3'd4
	} mode_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		mode_t             mode;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] now;
		logic              full;
		logic              wr_act;
		logic [TIME_W-1:0] wr_until;
		logic [CNT_W-1:0]  wr_fail;
		logic [CNT_W-1:0]  wr_pfail;
	} cmd_t;

	// token handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic              act;
		logic [TIME_W-1:0] due;
		logic [CNT_W-1:0]  fail;
		logic [CNT_W-1:0]  pfail;
		logic              full;
		logic              claimed;
	} tok_t;

endpackage

FILE: src/drbt_cell.sv
// one table entry: holds its state and passes the scan token to the next entry
module drbt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  drbt_pkg::cmd_t cmd,
	input  drbt_pkg::tok_t tok_in,
	output drbt_pkg::tok_t tok_out
);
	import drbt_pkg::*;

	logic              used_q;
	logic              act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] until_q;
	logic [CNT_W-1:0]  fail_q;
	logic [CNT_W-1:0]  pfail_q;
	tok_t              tok_q;

	logic addr_hit;
	logic is_free;
	logic do_write;
	logic do_take;
	logic do_clear;
	tok_t tok_n;

	assign addr_hit = used_q && (addr_q == cmd.addr);
	// fresh slot while the table has room, else an idle entry whose wait is over
	assign is_free  = cmd.full ? (!act_q && (cmd.now >= until_q)) : !used_q;

	// token update for the current pass
	always_comb begin
		tok_n    = tok_in;
		do_write = 1'b0;
		do_take  = 1'b0;
		do_clear = 1'b0;
		case (cmd.mode)
			MODE_LOOK: begin
				tok_n.full = tok_in.full & used_q;
				if (tok_in.vld && !tok_in.hit && addr_hit) begin
					tok_n.hit   = 1'b1;
					tok_n.act   = act_q;
					tok_n.due   = until_q;
					tok_n.fail  = fail_q;
					tok_n.pfail = pfail_q;
				end
			end
			MODE_WRHIT: begin
				if (tok_in.vld && !tok_in.claimed && addr_hit) begin
					do_write      = 1'b1;
					tok_n.claimed = 1'b1;
				end
			end
			MODE_TAKE: begin
				if (tok_in.vld && !tok_in.claimed && is_free) begin
					do_take       = 1'b1;
					tok_n.claimed = 1'b1;
				end
			end
			MODE_CLEAR: begin
				do_clear = tok_in.vld && used_q && !act_q;
			end
			default: begin
			end
		endcase
	end

	// control state and token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
			tok_q  <= '0;
		end else begin
			tok_q <= tok_n;
			if (do_take) begin
				used_q <= 1'b1;
				act_q  <= 1'b1;
			end else if (do_write) begin
				act_q <= cmd.wr_act;
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (do_take) begin
			addr_q  <= cmd.addr;
			until_q <= '0;
			fail_q  <= '0;
			pfail_q <= '0;
		end else if (do_write) begin
			until_q <= cmd.wr_until;
			fail_q  <= cmd.wr_fail;
			pfail_q <= cmd.wr_pfail;
		end else if (do_clear) begin
			until_q <= '0;
			fail_q  <= '0;
			pfail_q <= '0;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: src/device_retry_backoff_table_core.sv
// Retry backoff table: TABLE_ENTRIES device addresses held in a row of cells.
// One item at a time. A token walks the cell row once, one cell per cycle, to
// look the address up, and once more to write when the item needs a write pass
// (advertise of a new address, even when no entry is free, granted advertise,
// session end, clear); an item that needs none (advertise without a match or
// refused for a known address, query, session end for an unknown address)
// goes from the lookup straight to its result. A finished result sits in an
// output register, so the next item is taken while it waits; the next result
// then waits as long as that one is stalled.
// Configuration writes land at once and must come while the block is idle.
module device_retry_backoff_table_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  drbt_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output drbt_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [drbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drbt_pkg::CFG_W-1:0]          cfg_wdata
);
	import drbt_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE        = 8'b0000_0001,
		ST_LOOK_GO     = 8'b0000_0010,
		ST_LOOK_WAIT   = 8'b0000_0100,
		ST_CALC1       = 8'b0000_1000,
		ST_CALC2       = 8'b0001_0000,
		ST_COMMIT_GO   = 8'b0010_0000,
		ST_COMMIT_WAIT = 8'b0100_0000,
		ST_DONE        = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [BASE_W-1:0]  base_q;
	logic [MAX_W-1:0]   max_q;
	logic [RETRY_W-1:0] retry_q;
	logic [TRIES_W-1:0] tries_q;

	req_t  req_q;
	tok_t  lk_q;
	mode_t mode_q;
	logic  claimed_q;
	logic  res_grant_q;
	logic  res_active_q;

	// calculation stage one
	logic              wr_act_s1;
	logic [TIME_W-1:0] until_keep_s1;
	logic [CNT_W-1:0]  fbase_s1;
	logic [CNT_W-1:0]  pf_s1;
	logic              bo_s1;
	logic              use_wait_s1;
	logic [MAX_W-1:0]  wait_s1;

	// values written back by the commit pass
	logic              wr_act_q;
	logic [TIME_W-1:0] wr_until_q;
	logic [CNT_W-1:0]  wr_fail_q;
	logic [CNT_W-1:0]  wr_pfail_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	cmd_t cmd;
	tok_t tok_head;
	tok_t tok_c [TABLE_ENTRIES+1];

	logic req_fire;
	logic done_fire;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign done_fire = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_W'(15000);
			max_q   <= MAX_W'(300000);
			retry_q <= RETRY_W'(5000);
			tries_q <= TRIES_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BACKOFF_BASE:  base_q  <= cfg_wdata[BASE_W-1:0];
				CFG_BACKOFF_MAX:   max_q   <= cfg_wdata[MAX_W-1:0];
				CFG_CONNECT_RETRY: retry_q <= cfg_wdata[RETRY_W-1:0];
				CFG_PAIRING_TRIES: tries_q <= cfg_wdata[TRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// broadcast to the cell row and token injection
	always_comb begin
		cmd.mode     = ((state_q == ST_LOOK_GO) || (state_q == ST_LOOK_WAIT)) ?
			MODE_LOOK : mode_q;
		cmd.addr     = req_q.device_address;
		cmd.now      = req_q.time_ms;
		cmd.full     = lk_q.full;
		cmd.wr_act   = wr_act_q;
		cmd.wr_until = wr_until_q;
		cmd.wr_fail  = wr_fail_q;
		cmd.wr_pfail = wr_pfail_q;

		tok_head      = '0;
		tok_head.vld  = (state_q == ST_LOOK_GO) || (state_q == ST_COMMIT_GO);
		tok_head.full = 1'b1;
	end

	assign tok_c[0] = tok_head;

	// the cell row
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		drbt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.tok_in (tok_c[i]),
			.tok_out(tok_c[i+1])
		);
	end

	// outcome of the lookup, seen by stage one
	logic              sess;
	logic              pub;
	logic              pfl;
	logic [CNT_W-1:0]  f0;
	logic [CNT_W-1:0]  pf0;
	logic [TIME_W-1:0] u0;
	logic [CNT_W-1:0]  pf1;
	logic              bo;
	logic [SHIFT_W-1:0] sh;
	logic [SHL_W-1:0]  shifted;
	logic [MAX_W-1:0]  capped;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] sat_sum;

	always_comb begin
		sess    = (req_q.action == ACT_SESSION_END);
		pub     = sess && req_q.was_published;
		pfl     = sess && req_q.pair_failed;
		f0      = pub ? '0 : lk_q.fail;
		pf0     = pub ? '0 : lk_q.pfail;
		u0      = pub ? '0 : lk_q.due;
		pf1     = (pfl && (pf0 != COUNT_CAP)) ? pf0 + CNT_W'(1) : pf0;
		bo      = sess && (req_q.wants_backoff || (pfl && (pf1 >= tries_q)));
		sh      = (f0 > SHIFT_CAP) ? SHIFT_CAP[SHIFT_W-1:0] : f0[SHIFT_W-1:0];
		shifted = SHL_W'(base_q) << sh;
		capped  = (shifted > SHL_W'(max_q)) ? max_q : shifted[MAX_W-1:0];
		// deadline sum in stage two
		sum     = (TIME_W+1)'(req_q.time_ms) + (TIME_W+1)'(wait_s1);
		sat_sum = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_NONE;
			claimed_q    <= 1'b0;
			res_grant_q  <= 1'b0;
			res_active_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (done_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_LOOK_GO;
					end
				end
				ST_LOOK_GO: begin
					state_q <= ST_LOOK_WAIT;
				end
				ST_LOOK_WAIT: begin
					if (tok_c[TABLE_ENTRIES].vld) begin
						state_q <= ST_CALC1;
					end
				end
				ST_CALC1: begin
					claimed_q    <= 1'b0;
					res_grant_q  <= 1'b0;
					res_active_q <= 1'b0;
					mode_q       <= MODE_NONE;
					case (req_q.action)
						ACT_ADVERTISE: begin
							if (req_q.match_found) begin
								if (!lk_q.hit) begin
									mode_q <= MODE_TAKE;
								end else if (!lk_q.act && (req_q.time_ms >= lk_q.due)) begin
									mode_q      <= MODE_WRHIT;
									res_grant_q <= 1'b1;
								end
							end
						end
						ACT_SESSION_END: begin
							if (lk_q.hit) begin
								mode_q <= MODE_WRHIT;
							end
						end
						ACT_CLEAR: begin
							mode_q <= MODE_CLEAR;
						end
						ACT_QUERY: begin
							res_active_q <= lk_q.hit && lk_q.act;
						end
						default: begin
						end
					endcase
					state_q <= ST_CALC2;
				end
				ST_CALC2: begin
					state_q <= (mode_q == MODE_NONE) ? ST_DONE : ST_COMMIT_GO;
				end
				ST_COMMIT_GO: begin
					state_q <= ST_COMMIT_WAIT;
				end
				ST_COMMIT_WAIT: begin
					if (tok_c[TABLE_ENTRIES].vld) begin
						claimed_q <= tok_c[TABLE_ENTRIES].claimed;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, lookup result and arithmetic
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if ((state_q == ST_LOOK_WAIT) && tok_c[TABLE_ENTRIES].vld) begin
			lk_q <= tok_c[TABLE_ENTRIES];
		end
		if (state_q == ST_CALC1) begin
			wr_act_s1     <= (req_q.action == ACT_ADVERTISE);
			until_keep_s1 <= u0;
			fbase_s1      <= f0;
			pf_s1         <= pf1;
			bo_s1         <= bo;
			use_wait_s1   <= bo || (sess && req_q.conn_failed);
			wait_s1       <= bo ? capped : MAX_W'(retry_q);
		end
		if (state_q == ST_CALC2) begin
			wr_act_q   <= wr_act_s1;
			wr_until_q <= use_wait_s1 ? sat_sum : until_keep_s1;
			wr_fail_q  <= (bo_s1 && (fbase_s1 != COUNT_CAP)) ?
				fbase_s1 + CNT_W'(1) : fbase_s1;
			wr_pfail_q <= pf_s1;
		end
	end

	// result register
	logic res_granted;

	assign res_granted = res_grant_q || ((mode_q == MODE_TAKE) && claimed_q);

	always_ff @(posedge clk) begin
		if (done_fire) begin
			rsp_q.granted         <= res_granted;
			rsp_q.is_active       <= res_active_q;
			rsp_q.granted_family  <= res_granted ? req_q.match_family : 4'd0;
			rsp_q.granted_variant <= res_granted ? req_q.match_variant : 8'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: src/drbt_checker.sv
// port-level checks of the retry backoff table, bound to the top level
`include "assert_macros.svh"

module drbt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input drbt_pkg::rsp_t rsp
);
	import drbt_pkg::*;

	// a waiting result holds still
	`DRBT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one item at a time: the block is busy right after it takes an item
	`DRBT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)

	// the match echo is zero unless the session was granted
	`DRBT_ASSERT_SAME(a_echo_zero, clk, arst_n, rsp_valid && !rsp.granted, (rsp.granted_family == 4'd0) && (rsp.granted_variant == 8'd0))

	// grant and active mark come from different actions
	`DRBT_ASSERT_SAME(a_grant_or_active, clk, arst_n, rsp_valid, !(rsp.granted && rsp.is_active))

endmodule

bind device_retry_backoff_table_core drbt_checker u_drbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

FILE: tb/device_retry_backoff_table_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the device retry backoff table core
module device_retry_backoff_table_core_tb;
	import drbt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int POOL_SIZE = 24;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
	localparam int PHASE_ITEMS = 45;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;

	// session outcome bits: {wants_backoff, was_published, pair_failed, conn_failed}
	localparam logic [3:0] OUT_NONE      = 4'b0000;
	localparam logic [3:0] OUT_BACKOFF   = 4'b1000;
	localparam logic [3:0] OUT_PUBLISHED = 4'b0100;
	localparam logic [3:0] OUT_PAIR_FAIL = 4'b0010;
	localparam logic [3:0] OUT_CONN_FAIL = 4'b0001;

	// table predictor and reply checker
	class grant_scoreboard;
		bit [BASE_W-1:0] base_ms;
		bit [MAX_W-1:0] max_ms;
		bit [RETRY_W-1:0] retry_ms;
		bit [TRIES_W-1:0] tries;
		int used;
		bit [ADDR_W-1:0] slot_addr[ENTRIES];
		bit slot_active[ENTRIES];
		bit [TIME_W-1:0] slot_due[ENTRIES];
		bit [CNT_W-1:0] slot_fails[ENTRIES];
		bit [CNT_W-1:0] slot_pfails[ENTRIES];
		rsp_t expected_replies[$];
		int errors;
		int requests;
		int replies;
		int grants;

		function void reset_table();
			base_ms = 20'd15000;
			max_ms = 22'd300000;
			retry_ms = 20'd5000;
			tries = 8'd3;
			used = 0;
			foreach (slot_active[i]) begin
				slot_addr[i] = '0;
				slot_active[i] = 1'b0;
				slot_due[i] = '0;
				slot_fails[i] = '0;
				slot_pfails[i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_BACKOFF_BASE: base_ms = val[BASE_W-1:0];
				CFG_BACKOFF_MAX: max_ms = val[MAX_W-1:0];
				CFG_CONNECT_RETRY: retry_ms = val[RETRY_W-1:0];
				CFG_PAIRING_TRIES: tries = val[TRIES_W-1:0];
				default: ;
			endcase
		endfunction

		// lowest entry holding the address, or -1
		function int find_slot(logic [ADDR_W-1:0] a);
			for (int i = 0; i < used; i++)
				if (slot_addr[i] == a) return i;
			return -1;
		endfunction

		// fresh slot first, then an idle entry whose wait is over
		function int claim_slot(logic [TIME_W-1:0] now);
			if (used < ENTRIES) begin
				used++;
				return used - 1;
			end
			for (int i = 0; i < ENTRIES; i++)
				if (!slot_active[i] && now >= slot_due[i]) return i;
			return -1;
		endfunction

		// saturating deadline
		function bit [TIME_W-1:0] deadline(logic [TIME_W-1:0] now, logic [MAX_W-1:0] hold);
			bit [TIME_W:0] sum;
			sum = {1'b0, now} + hold;
			return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
		endfunction

		function void clear_counters(int e);
			slot_due[e] = '0;
			slot_fails[e] = '0;
			slot_pfails[e] = '0;
		endfunction

		function void note_request(req_t r);
			rsp_t exp_r;
			int e;
			int sh;
			bit backoff;
			bit [BASE_W+4:0] hold;
			exp_r = '0;
			requests++;
			case (r.action)
				ACT_ADVERTISE: begin
					if (r.match_found) begin
						e = find_slot(r.device_address);
						if (e >= 0) begin
							if (slot_active[e] || r.time_ms < slot_due[e]) e = -1;
						end else begin
							e = claim_slot(r.time_ms);
							if (e >= 0) begin
								slot_addr[e] = r.device_address;
								clear_counters(e);
							end
						end
						if (e >= 0) begin
							slot_active[e] = 1'b1;
							exp_r.granted = 1'b1;
							exp_r.granted_family = r.match_family;
							exp_r.granted_variant = r.match_variant;
							grants++;
						end
					end
				end
				ACT_SESSION_END: begin
					e = find_slot(r.device_address);
					if (e >= 0) begin
						slot_active[e] = 1'b0;
						if (r.was_published) clear_counters(e);
						backoff = r.wants_backoff;
						if (r.pair_failed) begin
							if (slot_pfails[e] != COUNT_CAP) slot_pfails[e]++;
							if (slot_pfails[e] >= tries) backoff = 1'b1;
						end
						if (backoff) begin
							sh = (slot_fails[e] > SHIFT_CAP) ? int'(SHIFT_CAP) : int'(slot_fails[e]);
							hold = {5'd0, base_ms} << sh;
							if (hold > max_ms) hold = max_ms;
							slot_due[e] = deadline(r.time_ms, hold[MAX_W-1:0]);
							if (slot_fails[e] != COUNT_CAP) slot_fails[e]++;
						end else if (r.conn_failed) begin
							slot_due[e] = deadline(r.time_ms, retry_ms);
						end
					end
				end
				ACT_CLEAR: begin
					for (int i = 0; i < used; i++)
						if (!slot_active[i]) clear_counters(i);
				end
				default: begin
					e = find_slot(r.device_address);
					if (e >= 0) exp_r.is_active = slot_active[e];
				end
			endcase
			expected_replies.push_back(exp_r);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			replies++;
			if (expected_replies.size() == 0) begin
				$error("reply %h with no request outstanding", got);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			compare("granted", want.granted, got.granted);
			compare("is_active", want.is_active, got.is_active);
			compare("granted_family", want.granted_family, got.granted_family);
			compare("granted_variant", want.granted_variant, got.granted_variant);
		endfunction

		// address of a random active entry, if there is one
		function bit pick_active(output logic [ADDR_W-1:0] a);
			int idx[$];
			a = '0;
			for (int i = 0; i < used; i++)
				if (slot_active[i]) idx.push_back(i);
			if (idx.size() == 0) return 1'b0;
			a = slot_addr[idx[$urandom_range(0, idx.size() - 1)]];
			return 1'b1;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	grant_scoreboard sb;
	logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
	logic [TIME_W-1:0] clock_ms = '0;
	bit idle_on = 1'b0;
	bit stall_on = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int settings = 1;

	device_retry_backoff_table_core #(
		.TABLE_ENTRIES(ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// mostly short bursts, a few long ones
	function automatic int burst_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) return $urandom_range(1, 3);
		if (pick < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// reply side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (stall_on && $urandom_range(0, 99) < 25) begin
			stall_left = burst_length() - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_reply(rsp);
			if (req_valid && !req_stall) sb.note_request(req);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no item moved for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic req_t make_req(logic [1:0] act, logic [ADDR_W-1:0] a,
			logic [TIME_W-1:0] t, logic found = 1'b1, logic [3:0] fam = 4'd0,
			logic [7:0] vrt = 8'd0, logic [3:0] outcome = OUT_NONE);
		req_t r;
		r.action = act;
		r.device_address = a;
		r.time_ms = t;
		r.match_found = found;
		r.match_family = fam;
		r.match_variant = vrt;
		{r.wants_backoff, r.was_published, r.pair_failed, r.conn_failed} = outcome;
		return r;
	endfunction

	// mostly advertise / session-end pairs on a small address pool
	function automatic req_t random_request();
		req_t r;
		logic [127:0] raw;
		logic [ADDR_W-1:0] a;
		int pick;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		if ($urandom_range(0, 99) < 3)
			clock_ms += $urandom_range(100000, 6000000);
		else
			clock_ms += $urandom_range(0, 3000);
		pick = $urandom_range(0, 99);
		if (pick < 88)
			r.time_ms = clock_ms;
		else if (pick < 93)
			r.time_ms = clock_ms - $urandom_range(0, 20000);
		else if (pick >= 97)
			r.time_ms = TIME_TOP - $urandom_range(0, 5000000);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.action = ACT_ADVERTISE;
			r.device_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			r.match_found = ($urandom_range(0, 9) != 0);
		end else if (pick < 85) begin
			r.action = (pick < 75) ? ACT_SESSION_END : ACT_QUERY;
			if (!sb.pick_active(a) || $urandom_range(0, 4) == 0)
				a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			r.device_address = a;
			r.wants_backoff = ($urandom_range(0, 3) == 0);
			r.was_published = ($urandom_range(0, 3) == 0);
			r.pair_failed = ($urandom_range(0, 9) < 4);
			r.conn_failed = ($urandom_range(0, 9) < 4);
		end else if (pick < 89) begin
			r.action = ACT_CLEAR;
		end else if (pick < 95) begin
			r.device_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		end
		return r;
	endfunction

	function automatic int request_gap();
		if (!idle_on || $urandom_range(0, 1) == 0) return 0;
		return burst_length();
	endfunction

	task automatic send(req_t r);
		int gap;
		gap = request_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// wait until every reply is back and the table walk has settled
	task automatic finish_items();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic load_settings(logic [CFG_W-1:0] base, logic [CFG_W-1:0] cap,
			logic [CFG_W-1:0] retry, logic [CFG_W-1:0] tries);
		put_reg(CFG_BACKOFF_BASE, base);
		put_reg(CFG_BACKOFF_MAX, cap);
		put_reg(CFG_CONNECT_RETRY, retry);
		put_reg(CFG_PAIRING_TRIES, tries);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic reroll_idling();
		idle_on = ($urandom_range(0, 3) != 0);
		stall_on = ($urandom_range(0, 3) != 0);
	endtask

	initial begin
		logic [ADDR_W-1:0] a0;
		logic [ADDR_W-1:0] a1;
		logic [ADDR_W-1:0] a2;
		logic [TIME_W-1:0] t0;
		sb = new();
		sb.reset_table();
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		addr_pool[2] = 48'hAAAA_AAAA_AAAA;
		addr_pool[3] = 48'h5555_5555_5555;
		for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = {16'($urandom), $urandom};
		a0 = addr_pool[0];
		a1 = addr_pool[1];
		a2 = addr_pool[2];
		t0 = 48'd1000;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refusals, waits, clear, saturating deadline, reset settings
		reroll_idling();
		send(make_req(ACT_QUERY, a0, t0));
		send(make_req(ACT_SESSION_END, a0, t0, 1'b1, 4'd0, 8'd0, OUT_CONN_FAIL));
		send(make_req(ACT_ADVERTISE, a0, t0, 1'b0, 4'hF, 8'hFF));
		send(make_req(ACT_ADVERTISE, a0, t0, 1'b1, 4'hF, 8'hFF));
		send(make_req(ACT_ADVERTISE, a0, t0, 1'b1, 4'h3, 8'h11));
		send(make_req(ACT_QUERY, a0, t0));
		send(make_req(ACT_SESSION_END, a0, t0, 1'b1, 4'd0, 8'd0,
			OUT_PAIR_FAIL | OUT_CONN_FAIL));
		send(make_req(ACT_ADVERTISE, a0, t0 + 4999, 1'b1, 4'h1, 8'h01));
		send(make_req(ACT_ADVERTISE, a0, t0 + 5000, 1'b1, 4'h0, 8'h00));
		send(make_req(ACT_SESSION_END, a0, t0 + 5000, 1'b1, 4'd0, 8'd0, OUT_PAIR_FAIL));
		send(make_req(ACT_ADVERTISE, a0, t0 + 5000, 1'b1, 4'h2, 8'h80));
		send(make_req(ACT_SESSION_END, a0, t0 + 5000, 1'b1, 4'd0, 8'd0, OUT_PAIR_FAIL));
		send(make_req(ACT_ADVERTISE, a0, t0 + 19999, 1'b1, 4'h2, 8'h80));
		send(make_req(ACT_CLEAR, a1, t0));
		send(make_req(ACT_ADVERTISE, a0, t0 + 19999, 1'b1, 4'h7, 8'h7F));
		send(make_req(ACT_SESSION_END, a0, t0, 1'b1, 4'd0, 8'd0,
			OUT_PUBLISHED | OUT_BACKOFF));
		send(make_req(ACT_ADVERTISE, a1, TIME_TOP - 10, 1'b1, 4'h9, 8'h5A));
		send(make_req(ACT_SESSION_END, a1, TIME_TOP - 10, 1'b1, 4'd0, 8'd0, OUT_BACKOFF));
		send(make_req(ACT_ADVERTISE, a1, TIME_TOP - 1, 1'b1, 4'h9, 8'h5A));
		send(make_req(ACT_ADVERTISE, a1, TIME_TOP, 1'b1, 4'hA, 8'hA5));
		send(make_req(ACT_QUERY, a1, t0));
		send(make_req(ACT_CLEAR, a0, TIME_TOP));
		send(make_req(ACT_QUERY, a0, t0));
		send(make_req(ACT_ADVERTISE, addr_pool[3], TIME_TOP, 1'b1, 4'h5, 8'hC3));
		finish_items();

		// counter saturation: zero base so every backoff expires at once
		load_settings(0, 4000000, 0, 255);
		clock_ms = 48'd100000;
		send(make_req(ACT_ADVERTISE, a2, clock_ms, 1'b1, 4'h6, 8'h3C));
		repeat (260) begin
			send(make_req(ACT_SESSION_END, a2, clock_ms, 1'b1, 4'd0, 8'd0,
				OUT_BACKOFF | OUT_PAIR_FAIL));
		end
		finish_items();
		// shift is capped at five with both counters saturated
		load_settings(1000, 4000000, 0, 255);
		send(make_req(ACT_ADVERTISE, a2, clock_ms, 1'b1, 4'h6, 8'h3C));
		send(make_req(ACT_SESSION_END, a2, clock_ms, 1'b1, 4'd0, 8'd0, OUT_PAIR_FAIL));
		send(make_req(ACT_ADVERTISE, a2, clock_ms + 31999, 1'b1, 4'h6, 8'h3C));
		send(make_req(ACT_ADVERTISE, a2, clock_ms + 32000, 1'b1, 4'h6, 8'h3C));
		send(make_req(ACT_SESSION_END, a2, clock_ms, 1'b1, 4'd0, 8'd0, OUT_PUBLISHED));
		finish_items();

		// random phases over several register settings
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: load_settings(15000, 300000, 5000, 3);
				1: load_settings(1, 1, 0, 1);
				2: load_settings(1000000, 4000000, 1000000, 255);
				3: load_settings(0, 300000, 0, 0);
				4: load_settings(20'hFFFFF, 22'h3FFFFF, 20'hFFFFF, 8'hFF);
				default: load_settings($urandom_range(1, 1000000), $urandom_range(1, 4000000),
					$urandom_range(0, 1000000), $urandom_range(1, 255));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 30 == 0) reroll_idling();
				send(random_request());
			end
			finish_items();
		end

		// wrap up
		if (sb.expected_replies.size() != 0) begin
			$error("%0d replies never arrived", sb.expected_replies.size());
			sb.errors += sb.expected_replies.size();
		end
		$display("%0d requests sent over %0d register settings", sb.requests, settings);
		$display("%0d replies checked, %0d sessions granted", sb.replies, sb.grants);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/drbt_pkg.sv
src/drbt_cell.sv
src/device_retry_backoff_table_core.sv
src/drbt_checker.sv
tb/device_retry_backoff_table_core_tb.sv
